### hdl/mpbt_pkg.sv
// Shared types and constants for the measure phase beat trigger.
package mpbt_pkg;

    // Input item actions
    typedef enum logic [2:0] {
        ACT_TICK  = 3'd0,
        ACT_START = 3'd1,
        ACT_STOP  = 3'd2,
        ACT_CLEAR = 3'd3,
        ACT_LOAD  = 3'd4
    } t_action;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_ADD,
        ST_EVAL,
        ST_WALK,
        ST_MAP,
        ST_WRITE,
        ST_FIN
    } t_state;

    // Configuration register indexes
    localparam logic [1:0] CFG_PHASE_STEP = 2'd0;
    localparam logic [1:0] CFG_PHASE_REM  = 2'd1;
    localparam logic [1:0] CFG_LOOP       = 2'd2;

    localparam logic [15:0] STEP_RESET = 16'd1073;
    localparam logic [31:0] REM_RESET  = 32'd3186109619;

    // Flash codes
    localparam logic [1:0] FLASH_NONE     = 2'd0;
    localparam logic [1:0] FLASH_QUARTER  = 2'd1;
    localparam logic [1:0] FLASH_DOWNBEAT = 2'd2;

    localparam logic [31:0] PHASE_Q1       = 32'h4000_0000;
    localparam logic [31:0] PHASE_Q2       = 32'h8000_0000;
    localparam logic [31:0] PHASE_Q3       = 32'hC000_0000;
    localparam logic [31:0] PHASE_ALL_ONES = 32'hFFFF_FFFF;
    localparam logic [15:0] MEASURE_MAX    = 16'hFFFF;

    // Position mapping: t = (pos - 96) * 2^16 / 3904, clamped to 0xFFFF
    localparam logic [11:0] POS_MIN   = 12'd96;
    localparam logic [11:0] POS_SPAN  = 12'd3904;
    localparam int          MAP_SHIFT = 40;
    localparam logic [28:0] MAP_RECIP = 29'((64'd1 << MAP_SHIFT) / 64'd3904);
    localparam logic [16:0] T_MAX     = 17'h0_FFFF;

    // One stored beat
    typedef struct packed {
        logic [31:0] phase;
        logic [1:0]  track;
        logic        accent;
    } t_beat;

endpackage

### hdl/mpbt_ram.sv
// Generic single-write, single-read RAM with registered read data.
module mpbt_ram #(
    parameter int WIDTH = 35,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

### hdl/mpbt_posmap.sv
// Raw beat position to measure phase mapper, one register stage.
module mpbt_posmap import mpbt_pkg::*; (
    input  logic        i_clk,
    input  logic [11:0] i_position,
    output logic [31:0] o_phase
);

    logic [27:0] w_num;
    logic [56:0] w_prod;
    logic [27:0] r_num;
    logic [16:0] r_quot;
    logic [28:0] w_back;
    logic [28:0] w_rem;
    logic [16:0] w_quot;
    logic [15:0] w_t;

    // Scale the offset by 2^16; positions at or below the floor map to zero
    assign w_num  = (i_position > POS_MIN) ? {i_position - POS_MIN, 16'd0} : '0;
    // Reciprocal estimate, at most one below the true quotient
    assign w_prod = 57'(w_num) * 57'(MAP_RECIP);

    always_ff @(posedge i_clk) begin
        r_num  <= w_num;
        r_quot <= w_prod[56:40];
    end

    // Correct the estimate by one compare and clamp
    assign w_back = 29'(r_quot) * 29'(POS_SPAN);
    assign w_rem  = 29'(r_num) - w_back;
    assign w_quot = (w_rem >= 29'(POS_SPAN)) ? r_quot + 17'd1 : r_quot;
    assign w_t    = (w_quot >= T_MAX) ? T_MAX[15:0] : w_quot[15:0];
    assign o_phase = {w_t, w_t};

endmodule

### hdl/measure_phase_beat_trigger.sv
// Top level of the measure phase beat trigger: sequencer, phase state and beat table.
//
// Every input transaction yields exactly one output transaction. A tick while
// playing multiplies elapsed time by the step and remainder (ST_MUL), adds
// (ST_ADD) and evaluates wrap and quarter crossings (ST_EVAL), then walks the
// stored beats one at a time (ST_WALK), as the beat table RAM has a single
// read port, and loads the output register in ST_FIN once it is free. A tick
// that ends the measure without looping, or that finds the table empty, skips
// the beat walk. A beat load that is not dropped passes through the position
// mapper stage (ST_MAP), the table write (ST_WRITE) and ST_FIN; every other
// transaction goes straight to ST_FIN. The next input transaction is taken in
// the idle state that follows. A new input transaction is taken as soon as the
// result of the previous one sits in the output register, even while the
// downstream side stalls it. The beat table needs no clearing pass: only entries
// below the fill count are ever read. Configuration may be written only while idle.
module measure_phase_beat_trigger import mpbt_pkg::*; #(
    parameter int MAX_BEATS  = 16,
    parameter int NUM_TRACKS = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration write port
    input  logic        i_cfg_wr_en,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_wdata,
    // input channel
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [2:0]  i_action,
    input  logic [31:0] i_elapsed_us,
    input  logic [11:0] i_beat_position,
    input  logic [1:0]  i_beat_track,
    input  logic        i_beat_accent,
    // output channel
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [1:0]  o_tempo_flash,
    output logic [3:0]  o_track_hits,
    output logic [3:0]  o_track_accents,
    output logic        o_is_playing,
    output logic [31:0] o_phase_now,
    output logic [15:0] o_measures_played
);

    localparam int AW = (MAX_BEATS > 1) ? $clog2(MAX_BEATS) : 1;
    localparam int CW = $clog2(MAX_BEATS + 1);
    localparam int BW = $bits(t_beat);

    t_state r_state, n_state;

    // configuration
    logic [15:0] r_cfg_step;
    logic [31:0] r_cfg_rem;
    logic        r_cfg_loop;

    // architectural state
    logic          r_running, n_running;
    logic [31:0]   r_phase, n_phase;
    logic [31:0]   r_prev_phase, n_prev_phase;
    logic [31:0]   r_err, n_err;
    logic [31:0]   r_prev_err, n_prev_err;
    logic [15:0]   r_measure, n_measure;
    logic [CW-1:0] r_count, n_count;

    // per-transaction working state
    logic [AW-1:0] r_idx, n_idx;
    logic          r_wrapped, n_wrapped;
    logic [1:0]    r_flash, n_flash;
    logic [3:0]    r_hits, n_hits;
    logic [3:0]    r_accents, n_accents;
    logic          r_out_valid, n_out_valid;

    // captured transaction and datapath registers
    logic [31:0] r_elapsed;
    logic [11:0] r_position;
    logic [1:0]  r_track;
    logic        r_accent;
    logic [31:0] r_prod_step;
    logic [31:0] r_prod_rem;
    logic [31:0] r_phase_sum;

    // output register
    logic [1:0]  r_out_flash;
    logic [3:0]  r_out_hits;
    logic [3:0]  r_out_accents;
    logic        r_out_playing;
    logic [31:0] r_out_phase;
    logic [15:0] r_out_measure;

    logic          w_in_accept;
    logic          w_out_load;
    logic [47:0]   w_mul_step;
    logic [63:0]   w_mul_rem;
    logic [31:0]   w_phase_new;
    logic          w_wrap;
    logic          w_stop;
    logic          w_quarter;
    logic [31:0]   w_map_phase;
    t_beat         w_wr_beat;
    t_beat         w_rd_beat;
    logic [BW-1:0] w_rd_data;
    logic          w_rd_en;
    logic [AW-1:0] w_rd_addr;
    logic          w_cross;
    logic [3:0]    w_bit;
    logic          w_last;
    logic          w_load_ok;

    assign w_in_accept = i_in_valid && !o_in_stall;
    assign o_in_stall  = (r_state != ST_IDLE);

    // Truncated products: only the low 32 bits matter modulo 2^32
    assign w_mul_step = 48'(r_elapsed) * 48'(r_cfg_step);
    assign w_mul_rem  = 64'(r_elapsed) * 64'(r_cfg_rem);

    // Error accumulator wrap carries one into the phase
    assign w_phase_new = r_phase_sum + {31'd0, (r_err < r_prev_err)};
    assign w_wrap      = (r_prev_phase > w_phase_new);
    assign w_stop      = w_wrap && !r_cfg_loop && (r_measure != '0);
    assign w_quarter   = (r_prev_phase < PHASE_Q1 && w_phase_new >= PHASE_Q1) ||
                         (r_prev_phase < PHASE_Q2 && w_phase_new >= PHASE_Q2) ||
                         (r_prev_phase < PHASE_Q3 && w_phase_new >= PHASE_Q3);

    assign w_load_ok = (r_count != CW'(MAX_BEATS)) && (int'(i_beat_track) < NUM_TRACKS);

    // Beat crossing test against the old and new phase
    assign w_rd_beat = t_beat'(w_rd_data);
    assign w_cross   = (r_prev_phase < w_rd_beat.phase && r_phase >= w_rd_beat.phase) ||
                       (r_wrapped && (r_prev_phase < w_rd_beat.phase ||
                                      r_phase >= w_rd_beat.phase));
    assign w_bit     = 4'b0001 << w_rd_beat.track;
    assign w_last    = (CW'(r_idx) == r_count - CW'(1));

    mpbt_posmap u_posmap (
        .i_clk      (i_clk),
        .i_position (r_position),
        .o_phase    (w_map_phase)
    );

    assign w_wr_beat = '{phase: w_map_phase, track: r_track, accent: r_accent};

    mpbt_ram #(
        .WIDTH (BW),
        .DEPTH (MAX_BEATS)
    ) u_beat_ram (
        .i_clk     (i_clk),
        .i_wr_en   (r_state == ST_WRITE),
        .i_wr_addr (r_count[AW-1:0]),
        .i_wr_data (w_wr_beat),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    // Next state and datapath control
    always_comb begin
        n_state      = r_state;
        n_running    = r_running;
        n_phase      = r_phase;
        n_prev_phase = r_prev_phase;
        n_err        = r_err;
        n_prev_err   = r_prev_err;
        n_measure    = r_measure;
        n_count      = r_count;
        n_idx        = r_idx;
        n_wrapped    = r_wrapped;
        n_flash      = r_flash;
        n_hits       = r_hits;
        n_accents    = r_accents;
        n_out_valid  = r_out_valid && i_out_stall;
        w_out_load   = 1'b0;
        w_rd_en      = 1'b0;
        w_rd_addr    = '0;

        case (r_state)
            ST_IDLE: begin
                if (w_in_accept) begin
                    n_flash   = FLASH_NONE;
                    n_hits    = '0;
                    n_accents = '0;
                    case (i_action)
                        ACT_TICK: begin
                            // a tick while stopped changes nothing
                            n_state = r_running ? ST_MUL : ST_FIN;
                        end
                        ACT_START: begin
                            n_running    = 1'b1;
                            n_phase      = '0;
                            n_prev_phase = PHASE_ALL_ONES;
                            n_err        = '0;
                            n_prev_err   = '0;
                            n_measure    = '0;
                            n_state      = ST_FIN;
                        end
                        ACT_STOP: begin
                            n_running = 1'b0;
                            n_state   = ST_FIN;
                        end
                        ACT_CLEAR: begin
                            n_count = '0;
                            n_state = ST_FIN;
                        end
                        ACT_LOAD: begin
                            // drop loads into a full table or onto a missing track
                            n_state = w_load_ok ? ST_MAP : ST_FIN;
                        end
                        default: begin
                            n_state = ST_FIN;
                        end
                    endcase
                end
            end
            ST_MUL: begin
                n_state = ST_ADD;
            end
            ST_ADD: begin
                n_err   = r_err + r_prod_rem;
                n_state = ST_EVAL;
            end
            ST_EVAL: begin
                n_phase   = w_phase_new;
                n_wrapped = w_wrap;
                if (w_stop) begin
                    // end of the only measure: stop, keep the previous phase and error marks
                    n_running = 1'b0;
                    n_state   = ST_FIN;
                end else begin
                    if (w_wrap) begin
                        if (r_measure != MEASURE_MAX) begin
                            n_measure = r_measure + 16'd1;
                        end
                        n_flash = FLASH_DOWNBEAT;
                    end else if (w_quarter) begin
                        n_flash = FLASH_QUARTER;
                    end
                    if (r_count == '0) begin
                        n_prev_phase = w_phase_new;
                        n_prev_err   = r_err;
                        n_state      = ST_FIN;
                    end else begin
                        w_rd_en   = 1'b1;
                        w_rd_addr = '0;
                        n_idx     = '0;
                        n_state   = ST_WALK;
                    end
                end
            end
            ST_WALK: begin
                if (w_cross) begin
                    n_hits    = r_hits | w_bit;
                    n_accents = w_rd_beat.accent ? (r_accents | w_bit) : (r_accents & ~w_bit);
                end
                if (w_last) begin
                    n_prev_phase = r_phase;
                    n_prev_err   = r_err;
                    n_state      = ST_FIN;
                end else begin
                    // advance to the next stored beat
                    n_idx     = r_idx + AW'(1);
                    w_rd_en   = 1'b1;
                    w_rd_addr = r_idx + AW'(1);
                end
            end
            ST_MAP: begin
                n_state = ST_WRITE;
            end
            ST_WRITE: begin
                n_count = r_count + CW'(1);
                n_state = ST_FIN;
            end
            ST_FIN: begin
                // hold until the output register is free
                if (!r_out_valid || !i_out_stall) begin
                    w_out_load  = 1'b1;
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control and architectural state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_cfg_step   <= STEP_RESET;
            r_cfg_rem    <= REM_RESET;
            r_cfg_loop   <= 1'b0;
            r_running    <= 1'b0;
            r_phase      <= '0;
            r_prev_phase <= PHASE_ALL_ONES;
            r_err        <= '0;
            r_prev_err   <= '0;
            r_measure    <= '0;
            r_count      <= '0;
            r_idx        <= '0;
            r_wrapped    <= 1'b0;
            r_flash      <= FLASH_NONE;
            r_hits       <= '0;
            r_accents    <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_running    <= n_running;
            r_phase      <= n_phase;
            r_prev_phase <= n_prev_phase;
            r_err        <= n_err;
            r_prev_err   <= n_prev_err;
            r_measure    <= n_measure;
            r_count      <= n_count;
            r_idx        <= n_idx;
            r_wrapped    <= n_wrapped;
            r_flash      <= n_flash;
            r_hits       <= n_hits;
            r_accents    <= n_accents;
            r_out_valid  <= n_out_valid;
            if (i_cfg_wr_en) begin
                case (i_cfg_index)
                    CFG_PHASE_STEP: r_cfg_step <= i_cfg_wdata[15:0];
                    CFG_PHASE_REM:  r_cfg_rem  <= i_cfg_wdata;
                    CFG_LOOP:       r_cfg_loop <= i_cfg_wdata[0];
                    default: ;
                endcase
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (w_in_accept) begin
            r_elapsed  <= i_elapsed_us;
            r_position <= i_beat_position;
            r_track    <= i_beat_track;
            r_accent   <= i_beat_accent;
        end
        if (r_state == ST_MUL) begin
            r_prod_step <= w_mul_step[31:0];
            r_prod_rem  <= w_mul_rem[31:0];
        end
        if (r_state == ST_ADD) begin
            r_phase_sum <= r_phase + r_prod_step;
        end
        if (w_out_load) begin
            r_out_flash   <= r_flash;
            r_out_hits    <= r_hits;
            r_out_accents <= r_accents;
            r_out_playing <= r_running;
            r_out_phase   <= r_phase;
            r_out_measure <= r_measure;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_tempo_flash     = r_out_flash;
    assign o_track_hits      = r_out_hits;
    assign o_track_accents   = r_out_accents;
    assign o_is_playing      = r_out_playing;
    assign o_phase_now       = r_out_phase;
    assign o_measures_played = r_out_measure;

    // An accepted transaction always leaves the block busy in the following cycle
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input accepted but block not busy");

    // The fill count never passes the table depth
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_BEATS))
        else $error("beat fill count out of range");

    // The beat walk only runs over a non-empty table
    a_walk_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_WALK) |-> (r_count != '0))
        else $error("beat walk with empty table");

    // A flash is only reported while playing
    a_flash_playing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_tempo_flash != FLASH_NONE) |-> o_is_playing)
        else $error("flash reported while stopped");

endmodule

### dv/tb_top.sv
// Self-checking testbench for the measure phase beat trigger: predictor, scoreboard and stimulus.
module tb_top;
    import mpbt_pkg::*;

    localparam int MAX_BEATS        = 16;
    localparam int NUM_TRACKS       = 4;
    localparam int NUM_ACTION_CODES = 8;
    // settle well past the longest tick, which walks all MAX_BEATS beats
    localparam int SETTLE_CYCLES    = 30;
    localparam int LONG_HOLD_CYCLES = 400;

    // One input transaction
    typedef struct packed {
        logic [2:0]  action;
        logic [31:0] elapsed;
        logic [11:0] position;
        logic [1:0]  track;
        logic        accent;
    } t_item;

    // One output transaction
    typedef struct packed {
        logic [1:0]  flash;
        logic [3:0]  hits;
        logic [3:0]  accents;
        logic        playing;
        logic [31:0] phase;
        logic [15:0] measures;
    } t_result;

    // Phase accumulator predictor plus the queue of results it has worked out.
    class beat_scoreboard;
        logic [15:0] cfg_step;
        logic [31:0] cfg_rem;
        logic        cfg_loop;
        logic [31:0] ph;
        logic [31:0] prev_ph;
        logic [31:0] err_acc;
        logic [31:0] prev_err;
        logic        playing;
        logic [15:0] measures;
        logic [31:0] beat_ph  [MAX_BEATS];
        logic [1:0]  beat_trk [MAX_BEATS];
        logic        beat_acc [MAX_BEATS];
        int          beat_count;
        t_result     flash_q[$];
        int          errors;

        function new();
            cfg_step   = STEP_RESET;
            cfg_rem    = REM_RESET;
            cfg_loop   = 1'b0;
            ph         = '0;
            prev_ph    = PHASE_ALL_ONES;
            err_acc    = '0;
            prev_err   = '0;
            playing    = 1'b0;
            measures   = '0;
            beat_count = 0;
            errors     = 0;
        endfunction

        function void write_reg(logic [1:0] idx, logic [31:0] data);
            case (idx)
                CFG_PHASE_STEP: cfg_step = data[15:0];
                CFG_PHASE_REM:  cfg_rem  = data;
                CFG_LOOP:       cfg_loop = data[0];
                default: ;
            endcase
        endfunction

        function int pending();
            return flash_q.size();
        endfunction

        function logic [31:0] position_to_phase(logic [11:0] pos);
            logic [31:0] t;
            if (pos <= POS_MIN) return '0;
            t = (32'(pos - POS_MIN) << 16) / 32'(POS_SPAN);
            if (t > 32'(T_MAX)) t = 32'(T_MAX);
            return {t[15:0], t[15:0]};
        endfunction

        function bit crosses(logic [31:0] mark);
            return prev_ph < mark && ph >= mark;
        endfunction

        // Advance the prediction by one accepted input and queue its result.
        function void note_input(t_item it);
            t_result     r;
            logic [63:0] step_prod;
            logic [63:0] rem_prod;
            bit          wrapped;
            bit          ended;
            r       = '0;
            ended   = 1'b0;
            case (it.action)
                ACT_TICK: if (playing) begin
                    step_prod = 64'(it.elapsed) * 64'(cfg_step);
                    rem_prod  = 64'(it.elapsed) * 64'(cfg_rem);
                    ph        = ph + step_prod[31:0];
                    err_acc   = err_acc + rem_prod[31:0];
                    if (err_acc < prev_err) ph = ph + 32'd1;
                    wrapped = prev_ph > ph;
                    if (wrapped) begin
                        if (!cfg_loop && measures != 16'd0) begin
                            playing = 1'b0;
                            ended   = 1'b1;
                        end else begin
                            if (measures != MEASURE_MAX) measures = measures + 16'd1;
                            r.flash = FLASH_DOWNBEAT;
                        end
                    end else if (crosses(PHASE_Q1) || crosses(PHASE_Q2) ||
                                 crosses(PHASE_Q3)) begin
                        r.flash = FLASH_QUARTER;
                    end
                    if (!ended) begin
                        for (int i = 0; i < beat_count; i++) begin
                            if (crosses(beat_ph[i]) ||
                                (wrapped && (prev_ph < beat_ph[i] || ph >= beat_ph[i]))) begin
                                r.hits[beat_trk[i]]    = 1'b1;
                                r.accents[beat_trk[i]] = beat_acc[i];
                            end
                        end
                        prev_ph  = ph;
                        prev_err = err_acc;
                    end
                end
                ACT_START: begin
                    playing  = 1'b1;
                    prev_ph  = PHASE_ALL_ONES;
                    ph       = '0;
                    err_acc  = '0;
                    prev_err = '0;
                    measures = '0;
                end
                ACT_STOP:  playing = 1'b0;
                ACT_CLEAR: beat_count = 0;
                ACT_LOAD: if (beat_count < MAX_BEATS && it.track < NUM_TRACKS) begin
                    beat_ph[beat_count]  = position_to_phase(it.position);
                    beat_trk[beat_count] = it.track;
                    beat_acc[beat_count] = it.accent;
                    beat_count++;
                end
                default: ;
            endcase
            r.playing  = playing;
            r.phase    = ph;
            r.measures = measures;
            flash_q.push_back(r);
        endfunction

        function void compare(string field, logic [31:0] want, logic [31:0] got);
            if (want !== got) begin
                errors++;
                $display("%0t: %s mismatch: expected %h, actual %h", $time, field, want, got);
            end
        endfunction

        function void check_result(t_result got);
            t_result want;
            if (flash_q.size() == 0) begin
                errors++;
                $display("%0t: unexpected result: expected none, actual phase %h",
                         $time, got.phase);
                return;
            end
            want = flash_q.pop_front();
            compare("tempo_flash", 32'(want.flash), 32'(got.flash));
            compare("track_hits", 32'(want.hits), 32'(got.hits));
            compare("track_accents", 32'(want.accents), 32'(got.accents));
            compare("is_playing", 32'(want.playing), 32'(got.playing));
            compare("phase_now", want.phase, got.phase);
            compare("measures_played", 32'(want.measures), 32'(got.measures));
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_cfg_wr_en;
    logic [1:0]  i_cfg_index;
    logic [31:0] i_cfg_wdata;
    logic        i_in_valid;
    logic        o_in_stall;
    logic [2:0]  i_action;
    logic [31:0] i_elapsed_us;
    logic [11:0] i_beat_position;
    logic [1:0]  i_beat_track;
    logic        i_beat_accent;
    logic        o_out_valid;
    logic        i_out_stall;
    logic [1:0]  o_tempo_flash;
    logic [3:0]  o_track_hits;
    logic [3:0]  o_track_accents;
    logic        o_is_playing;
    logic [31:0] o_phase_now;
    logic [15:0] o_measures_played;

    beat_scoreboard sb = new();

    // Knobs shared between the sender and the receiver
    bit quiet     = 1'b0;  // drop all idling on both sides
    bit long_hold = 1'b0;  // receiver: hold off for a long stretch, then clear
    int gap_pct   = 20;    // sender: chance of a gap before each transaction
    int counted   = 0;     // input transactions sent so far

    measure_phase_beat_trigger #(
        .MAX_BEATS  (MAX_BEATS),
        .NUM_TRACKS (NUM_TRACKS)
    ) uut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_wr_en       (i_cfg_wr_en),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_wdata       (i_cfg_wdata),
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_action          (i_action),
        .i_elapsed_us      (i_elapsed_us),
        .i_beat_position   (i_beat_position),
        .i_beat_track      (i_beat_track),
        .i_beat_accent     (i_beat_accent),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_tempo_flash     (o_tempo_flash),
        .o_track_hits      (o_track_hits),
        .o_track_accents   (o_track_accents),
        .o_is_playing      (o_is_playing),
        .o_phase_now       (o_phase_now),
        .o_measures_played (o_measures_played)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Check every output transaction; values read here are the ones from before the edge.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            sb.check_result({o_tempo_flash, o_track_hits, o_track_accents, o_is_playing,
                             o_phase_now, o_measures_played});
    end

    // Offer one input transaction and hold it until the block takes it. An optional
    // idle burst goes first; valid never looks at stall.
    task automatic send_item(t_item it);
        if (!quiet && $urandom_range(0, 99) < gap_pct) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge i_clk);
        end
        i_in_valid      <= 1'b1;
        i_action        <= it.action;
        i_elapsed_us    <= it.elapsed;
        i_beat_position <= it.position;
        i_beat_track    <= it.track;
        i_beat_accent   <= it.accent;
        do @(posedge i_clk); while (o_in_stall);
        counted++;
        sb.note_input(it);
    endtask

    // Drop valid and wait until every expected result is back, then let the block settle.
    task automatic drain();
        i_in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Write all three registers on consecutive edges; call only while drained.
    task automatic configure(logic [15:0] step_val, logic [31:0] rem_val, logic loop_val);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= CFG_PHASE_STEP;
        i_cfg_wdata <= 32'(step_val);
        @(posedge i_clk);
        i_cfg_index <= CFG_PHASE_REM;
        i_cfg_wdata <= rem_val;
        @(posedge i_clk);
        i_cfg_index <= CFG_LOOP;
        i_cfg_wdata <= 32'(loop_val);
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        sb.write_reg(CFG_PHASE_STEP, 32'(step_val));
        sb.write_reg(CFG_PHASE_REM, rem_val);
        sb.write_reg(CFG_LOOP, 32'(loop_val));
        @(posedge i_clk);
    endtask

    // Random payload with the given action.
    function automatic t_item rand_item(logic [2:0] action);
        t_item       it;
        logic [63:0] bits;
        bits      = {$urandom, $urandom};
        it        = bits[$bits(t_item)-1:0];
        it.action = action;
        return it;
    endfunction

    // Load a beat; a quarter of them sit on the corners of the position mapping.
    function automatic t_item load_item();
        t_item it;
        it = rand_item(ACT_LOAD);
        if ($urandom_range(0, 3) == 0) begin
            case ($urandom_range(0, 5))
                0: it.position = 12'd0;
                1: it.position = 12'd96;
                2: it.position = 12'd97;
                3: it.position = 12'd4000;
                4: it.position = 12'd4001;
                default: it.position = 12'hFFF;
            endcase
        end
        return it;
    endfunction

    // Tick whose elapsed time moves the phase about 1/parts of a measure at the
    // current rate, with some jitter; now and then zero or a raw random value.
    function automatic t_item tick_item(int parts);
        t_item       it;
        logic [63:0] rate;
        logic [63:0] span;
        it   = rand_item(ACT_TICK);
        rate = {16'd0, sb.cfg_step, sb.cfg_rem};
        if ($urandom_range(0, 9) == 0) begin
            it.elapsed = '0;
        end else if (rate >= 64'd2 && $urandom_range(0, 24) != 0) begin
            span = ((64'h8000_0000_0000_0000 / rate) << 1) / parts;
            if (span >= 64'hFFFF_FFFF) begin
                it.elapsed = '1;
            end else begin
                span = span + $urandom_range(0, span[31:0] >> 3);
                it.elapsed = (span > 64'hFFFF_FFFF) ? '1 : span[31:0];
            end
        end
        return it;
    endfunction

    // Mostly well-formed play sequences (optional clear, loads, start, ticks,
    // optional stop) with some noise between them.
    task automatic run_random(int target);
        int goal;
        int ticks;
        int parts;
        goal = counted + target;
        while (counted < goal) begin
            if ($urandom_range(0, 9) < 7) begin
                if ($urandom_range(0, 3) == 0) send_item(rand_item(ACT_CLEAR));
                repeat ($urandom_range(0, 6)) send_item(load_item());
                send_item(rand_item(ACT_START));
                ticks = $urandom_range(3, 30);
                parts = $urandom_range(1, 20);
                repeat (ticks) begin
                    if ($urandom_range(0, 11) == 0)
                        send_item(rand_item(3'($urandom_range(0, NUM_ACTION_CODES - 1))));
                    else
                        send_item(tick_item(parts));
                end
                if ($urandom_range(0, 2) == 0) send_item(rand_item(ACT_STOP));
            end else begin
                repeat ($urandom_range(1, 4))
                    send_item(rand_item(3'($urandom_range(0, NUM_ACTION_CODES - 1))));
            end
        end
    endtask

    // Receiver: random stall bursts, stretches without stalls, one long hold on request.
    initial begin
        i_out_stall <= 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            if (long_hold) begin
                i_out_stall <= 1'b1;
                repeat (LONG_HOLD_CYCLES) @(posedge i_clk);
                long_hold = 1'b0;
            end else if (quiet) begin
                i_out_stall <= 1'b0;
                @(posedge i_clk);
            end else begin
                case ($urandom_range(0, 3))
                    0: begin
                        i_out_stall <= 1'b1;
                        repeat ($urandom_range(1, 16)) @(posedge i_clk);
                    end
                    1: begin
                        i_out_stall <= 1'b0;
                        repeat ($urandom_range(20, 120)) @(posedge i_clk);
                    end
                    default: begin
                        i_out_stall <= 1'b0;
                        repeat ($urandom_range(1, 8)) @(posedge i_clk);
                    end
                endcase
            end
        end
    end

    // Main sequence: reset, directed transactions, then random phases under
    // several register settings, extremes included.
    initial begin
        i_rst_n         <= 1'b0;
        i_cfg_wr_en     <= 1'b0;
        i_cfg_index     <= CFG_PHASE_STEP;
        i_cfg_wdata     <= '0;
        i_in_valid      <= 1'b0;
        i_action        <= ACT_TICK;
        i_elapsed_us    <= '0;
        i_beat_position <= '0;
        i_beat_track    <= '0;
        i_beat_accent   <= 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part at the reset rate (about 4 s per measure), looping off.
        // tick while stopped, then the unused action codes
        send_item(t_item'{ACT_TICK, 32'hFFFF_FFFF, 12'hFFF, 2'd3, 1'b1});
        for (int a = int'(ACT_LOAD) + 1; a < NUM_ACTION_CODES; a++)
            send_item(t_item'{3'(a), 32'hFFFF_FFFF, 12'hFFF, 2'd3, 1'b1});
        send_item(t_item'{ACT_CLEAR, 32'd0, 12'd0, 2'd0, 1'b0});
        // beats on the corners of the mapping, three on track 0 with mixed accents
        send_item(t_item'{ACT_LOAD, 32'd0, 12'd0, 2'd0, 1'b1});
        send_item(t_item'{ACT_LOAD, 32'd0, 12'd96, 2'd1, 1'b0});
        send_item(t_item'{ACT_LOAD, 32'd0, 12'd97, 2'd2, 1'b1});
        send_item(t_item'{ACT_LOAD, 32'd0, 12'd1000, 2'd0, 1'b0});
        send_item(t_item'{ACT_LOAD, 32'd0, 12'd2048, 2'd3, 1'b1});
        send_item(t_item'{ACT_LOAD, 32'd0, 12'd4000, 2'd0, 1'b1});
        send_item(t_item'{ACT_LOAD, 32'd0, 12'hFFF, 2'd1, 1'b1});
        // first tick after start is the downbeat; then quarters; then the
        // measure ends and playback stops
        send_item(t_item'{ACT_START, 32'd0, 12'd0, 2'd0, 1'b0});
        send_item(t_item'{ACT_TICK, 32'd0, 12'd0, 2'd0, 1'b0});
        send_item(t_item'{ACT_TICK, 32'd1_100_000, 12'd0, 2'd0, 1'b0});
        send_item(t_item'{ACT_TICK, 32'd1_000_000, 12'd0, 2'd0, 1'b0});
        send_item(t_item'{ACT_TICK, 32'd2_500_000, 12'd0, 2'd0, 1'b0});
        send_item(t_item'{ACT_TICK, 32'd1000, 12'd0, 2'd0, 1'b0});
        // restart with the largest elapsed time, then stop and clear
        send_item(t_item'{ACT_START, 32'd0, 12'd0, 2'd0, 1'b0});
        send_item(t_item'{ACT_TICK, 32'd0, 12'd0, 2'd0, 1'b0});
        send_item(t_item'{ACT_TICK, 32'hFFFF_FFFF, 12'd0, 2'd0, 1'b0});
        send_item(t_item'{ACT_STOP, 32'd0, 12'd0, 2'd0, 1'b0});
        send_item(t_item'{ACT_CLEAR, 32'd0, 12'd0, 2'd0, 1'b0});

        run_random(150);

        // fastest rate, looping on; hold off the receiver while the sender keeps going
        drain();
        configure(16'hFFFF, 32'hFFFF_FFFF, 1'b1);
        gap_pct   = $urandom_range(5, 30);
        long_hold = 1'b1;
        run_random(160);

        // frozen rate, looping off
        drain();
        configure(16'd0, 32'd0, 1'b0);
        gap_pct = 0;
        run_random(100);

        // random rate; pause midway until every result is back
        drain();
        configure(16'($urandom_range(1, 8000)), $urandom, 1'b1);
        gap_pct = $urandom_range(10, 50);
        run_random(100);
        drain();
        run_random(100);

        // back to the reset rate
        drain();
        configure(STEP_RESET, REM_RESET, 1'b0);
        gap_pct = $urandom_range(0, 40);
        run_random(150);

        // fraction only, close to one phase unit per microsecond
        drain();
        configure(16'd0, 32'hFFFF_FFFF, 1'b1);
        gap_pct = $urandom_range(0, 40);
        run_random(120);

        // closing part: random settings, no idling on either side
        drain();
        configure(16'($urandom), $urandom, 1'($urandom));
        quiet = 1'b1;
        run_random(200);

        drain();
        if (sb.errors == 0 && sb.pending() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    // Hard limit, far above the slowest legal run
    initial begin
        #4_000_000;
        $display("FAIL");
        $finish;
    end

endmodule
